[design/bpsw_pkg.sv]
package bpsw_pkg;

  // Verdict codes on the result word.
  localparam logic [1:0] VERDICT_COMPOSITE = 2'd0;
  localparam logic [1:0] VERDICT_PRIME     = 2'd1;
  localparam logic [1:0] VERDICT_SQUARE    = 2'd2;

  // Operations of the shared modular unit.
  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_SUB  = 2'd2;
  localparam logic [1:0] OP_HALF = 2'd3;

  // Jacobi symbol codes.
  localparam logic [1:0] JAC_ZERO  = 2'd0;
  localparam logic [1:0] JAC_PLUS  = 2'd1;
  localparam logic [1:0] JAC_MINUS = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_req_t;

endpackage

[design/bpsw_modalu.sv]
module bpsw_modalu
  import bpsw_pkg::*;
#(
  parameter int W = 63
) (
  input  logic         clk,
  input  logic         rst,
  input  alu_req_t     req,
  input  logic [W-1:0] opa,
  input  logic [W-1:0] opb,
  input  logic [W-1:0] modulus,
  output logic         done,
  output logic [W-1:0] result
);

  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic          phase;
  logic [CW-1:0] cnt;
  logic [W-1:0]  acc;
  logic [W-1:0]  ma;
  logic [W-1:0]  mb;
  logic [W-1:0]  add_x;
  logic [W-1:0]  add_y;
  logic [W:0]    sum_w;
  logic [W-1:0]  add_res;
  logic [W-1:0]  sub_res;
  logic [W-1:0]  half_res;

  // One modular adder serves both the add operation and the multiplier steps.
  always_comb begin
    if (busy) begin
      add_x = acc;
      add_y = phase ? ma : acc;
    end else begin
      add_x = opa;
      add_y = opb;
    end
    sum_w   = {1'b0, add_x} + {1'b0, add_y};
    add_res = (sum_w >= {1'b0, modulus}) ? W'(sum_w - {1'b0, modulus}) : W'(sum_w);
    sub_res = (opa >= opb) ? (opa - opb) : W'({1'b0, opa} + {1'b0, modulus} - {1'b0, opb});
    half_res = opa[0] ? ((opa >> 1) + (modulus >> 1) + W'(1)) : (opa >> 1);
  end

  // A product walks the multiplier bits from the top: double, then add.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        if (!phase) begin
          acc   <= add_res;
          phase <= 1'b1;
        end else begin
          if (mb[W-1]) begin
            acc <= add_res;
          end
          mb    <= mb << 1;
          phase <= 1'b0;
          cnt   <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end else if (req.start) begin
        case (req.op)
          OP_MUL: begin
            acc   <= '0;
            ma    <= opa;
            mb    <= opb;
            cnt   <= CW'(W);
            phase <= 1'b0;
            busy  <= 1'b1;
          end
          OP_ADD: begin
            acc  <= add_res;
            done <= 1'b1;
          end
          OP_SUB: begin
            acc  <= sub_res;
            done <= 1'b1;
          end
          default: begin
            acc  <= half_res;
            done <= 1'b1;
          end
        endcase
      end
    end
  end

  assign result = acc;

endmodule

[design/bpsw_jacobi.sv]
module bpsw_jacobi
  import bpsw_pkg::*;
#(
  parameter int W = 63
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a_in,
  input  logic [W-1:0] n_in,
  output logic         done,
  output logic [1:0]   symbol
);

  logic         busy;
  logic         flip;
  logic [W-1:0] a;
  logic [W-1:0] m;

  // Binary form: strip a factor of two, swap, or subtract, one step a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        if (a == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (m == W'(1)) begin
            symbol <= flip ? JAC_MINUS : JAC_PLUS;
          end else begin
            symbol <= JAC_ZERO;
          end
        end else if (!a[0]) begin
          a <= a >> 1;
          if (m[2:0] == 3'd3 || m[2:0] == 3'd5) begin
            flip <= ~flip;
          end
        end else if (a < m) begin
          a <= m;
          m <= a;
          if (a[1:0] == 2'd3 && m[1:0] == 2'd3) begin
            flip <= ~flip;
          end
        end else begin
          a <= a - m;
        end
      end else if (start) begin
        a    <= a_in;
        m    <= n_in;
        flip <= 1'b0;
        busy <= 1'b1;
      end
    end
  end

endmodule

[design/baillie_psw_primality_test.sv]
// Baillie-PSW primality classifier.
// Input channel: in_valid / in_stall carry one word, candidate, the number to
// classify; only its low NUMBER_BITS bits are used. in_stall is high from the
// cycle after a word is taken until the verdict is loaded into the output.
// Output channel: out_valid / out_stall carry one word, verdict: 0 composite,
// 1 probable prime, 2 no Selfridge D found within MAX_D_TRIES tries.
// Latency is data dependent. Trivial inputs (below three, even) are settled
// in S_CHECK without either test. Otherwise every modular product runs on
// one shared shift-and-add unit. The base-2 test does NUMBER_BITS + 1
// squarings plus any further squarings of its strong loop. The Lucas test
// does up to five products per bit of n + 1. The Jacobi unit runs once per
// D tried.
// One word is in work at a time. The verdict sits in an output register; a
// new word can be taken while it waits, but the next verdict is held back
// until out_stall lets the first one go.
// Synchronous active-high rst returns the sequencer to idle and drops out_valid.
module baillie_psw_primality_test
  import bpsw_pkg::*;
#(
  parameter int NUMBER_BITS = 63,
  parameter int MAX_D_TRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [62:0] candidate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  verdict
);

  localparam int W     = NUMBER_BITS;
  localparam int EW    = W + 1;
  localparam int CW    = $clog2(EW + 1);
  localparam int SW    = $clog2(W + 1);
  localparam int TW    = $clog2(MAX_D_TRIES);
  localparam int MAG_W = $clog2(2 * MAX_D_TRIES + 6);
  localparam int XW    = ((W > MAG_W) ? W : MAG_W) + 1;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_CHECK    = 5'd1;
  localparam logic [4:0] S_B2_STRIP = 5'd2;
  localparam logic [4:0] S_B2_SQ    = 5'd3;
  localparam logic [4:0] S_B2_DBL   = 5'd4;
  localparam logic [4:0] S_B2_CHK   = 5'd5;
  localparam logic [4:0] S_B2_LOOP  = 5'd6;
  localparam logic [4:0] S_B2_LSQ   = 5'd7;
  localparam logic [4:0] S_D_RED    = 5'd8;
  localparam logic [4:0] S_D_JAC    = 5'd9;
  localparam logic [4:0] S_Q_RED    = 5'd10;
  localparam logic [4:0] S_L_STRIP  = 5'd11;
  localparam logic [4:0] S_L_UV     = 5'd12;
  localparam logic [4:0] S_L_VV     = 5'd13;
  localparam logic [4:0] S_L_QQ2    = 5'd14;
  localparam logic [4:0] S_L_VSUB   = 5'd15;
  localparam logic [4:0] S_L_QSQ    = 5'd16;
  localparam logic [4:0] S_L_ADD    = 5'd17;
  localparam logic [4:0] S_L_HALF   = 5'd18;
  localparam logic [4:0] S_L_DU     = 5'd19;
  localparam logic [4:0] S_L_DUV    = 5'd20;
  localparam logic [4:0] S_L_HALF2  = 5'd21;
  localparam logic [4:0] S_L_QM     = 5'd22;
  localparam logic [4:0] S_L_CHK    = 5'd23;
  localparam logic [4:0] S_LV_LOOP  = 5'd24;
  localparam logic [4:0] S_LV_VV    = 5'd25;
  localparam logic [4:0] S_LV_QQ2   = 5'd26;
  localparam logic [4:0] S_LV_VSUB  = 5'd27;
  localparam logic [4:0] S_LV_QSQ   = 5'd28;
  localparam logic [4:0] S_FIN      = 5'd29;

  logic [4:0]       state;
  logic             pend;
  logic [W-1:0]     n;
  logic [W-1:0]     nm1;
  logic [XW-1:0]    n_ext;
  logic [EW-1:0]    e;
  logic [CW-1:0]    cnt;
  logic [SW-1:0]    s;
  logic [SW-1:0]    r;
  logic [W-1:0]     x;
  logic [W-1:0]     u;
  logic [W-1:0]     v;
  logic [W-1:0]     qk;
  logic [W-1:0]     t;
  logic [W-1:0]     w;
  logic [W-1:0]     dm;
  logic [W-1:0]     qm;
  logic [XW-1:0]    red;
  logic             red_neg;
  logic [MAG_W-1:0] mag;
  logic             neg;
  logic [TW-1:0]    tries;
  logic [1:0]       res_code;

  alu_req_t     alu_req;
  logic         is_op;
  logic [W-1:0] opa;
  logic [W-1:0] opb;
  logic         alu_done;
  logic [W-1:0] alu_res;
  logic         jac_start;
  logic         jac_done;
  logic [1:0]   jac_symbol;
  logic [W-1:0] red_low;
  logic [W-1:0] red_res;
  logic         load_out;

  assign nm1      = n - W'(1);
  assign n_ext    = XW'(n);
  assign in_stall = (state != S_IDLE);
  assign red_low  = W'(red);
  // Residue of a small signed value once its magnitude is below n.
  assign red_res  = (red_neg && red_low != '0) ? (n - red_low) : red_low;
  // The finished verdict moves into the output register once it is free.
  assign load_out = (state == S_FIN) && (!out_valid || !out_stall);

  // Operation and operands that each arithmetic state asks of the shared unit.
  always_comb begin
    is_op = 1'b1;
    opa   = x;
    opb   = x;
    alu_req.op = OP_MUL;
    case (state)
      S_B2_SQ, S_B2_LSQ: begin
        alu_req.op = OP_MUL;
      end
      S_B2_DBL: begin
        alu_req.op = OP_ADD;
      end
      S_L_UV: begin
        alu_req.op = OP_MUL; opa = u; opb = v;
      end
      S_L_VV, S_LV_VV: begin
        alu_req.op = OP_MUL; opa = v; opb = v;
      end
      S_L_QQ2, S_LV_QQ2: begin
        alu_req.op = OP_ADD; opa = qk; opb = qk;
      end
      S_L_VSUB, S_LV_VSUB: begin
        alu_req.op = OP_SUB; opa = t; opb = w;
      end
      S_L_QSQ, S_LV_QSQ: begin
        alu_req.op = OP_MUL; opa = qk; opb = qk;
      end
      S_L_ADD: begin
        alu_req.op = OP_ADD; opa = u; opb = v;
      end
      S_L_HALF: begin
        alu_req.op = OP_HALF; opa = t; opb = t;
      end
      S_L_DU: begin
        alu_req.op = OP_MUL; opa = dm; opb = u;
      end
      S_L_DUV: begin
        alu_req.op = OP_ADD; opa = w; opb = v;
      end
      S_L_HALF2: begin
        alu_req.op = OP_HALF; opa = w; opb = w;
      end
      S_L_QM: begin
        alu_req.op = OP_MUL; opa = qk; opb = qm;
      end
      default: begin
        is_op = 1'b0;
      end
    endcase
    alu_req.start = is_op && !pend;
  end

  assign jac_start = (state == S_D_JAC) && !pend;

  bpsw_modalu #(.W(W)) u_alu (
    .clk     (clk),
    .rst     (rst),
    .req     (alu_req),
    .opa     (opa),
    .opb     (opb),
    .modulus (n),
    .done    (alu_done),
    .result  (alu_res)
  );

  bpsw_jacobi #(.W(W)) u_jacobi (
    .clk    (clk),
    .rst    (rst),
    .start  (jac_start),
    .a_in   (dm),
    .n_in   (n),
    .done   (jac_done),
    .symbol (jac_symbol)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (alu_req.start || jac_start) begin
        pend <= 1'b1;
      end
      if (alu_done || jac_done) begin
        pend <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            n     <= W'(candidate);
            state <= S_CHECK;
          end
        end

        S_CHECK: begin
          state <= S_FIN;
          if (n < W'(2)) begin
            res_code <= VERDICT_COMPOSITE;
          end else if (n == W'(2)) begin
            res_code <= VERDICT_PRIME;
          end else if (!n[0]) begin
            res_code <= VERDICT_COMPOSITE;
          end else begin
            e     <= EW'(nm1);
            s     <= '0;
            state <= S_B2_STRIP;
          end
        end

        // Base-2 strong test: 2^d by squaring and doubling, MSB first.
        S_B2_STRIP: begin
          if (!e[0]) begin
            e <= e >> 1;
            s <= s + SW'(1);
          end else begin
            cnt   <= CW'(EW);
            x     <= W'(1);
            state <= S_B2_SQ;
          end
        end

        S_B2_SQ: begin
          if (alu_done) begin
            x <= alu_res;
            if (e[EW-1]) begin
              state <= S_B2_DBL;
            end else if (cnt == CW'(1)) begin
              state <= S_B2_CHK;
            end else begin
              cnt   <= cnt - CW'(1);
              e     <= e << 1;
              state <= S_B2_SQ;
            end
          end
        end

        S_B2_DBL: begin
          if (alu_done) begin
            x <= alu_res;
            if (cnt == CW'(1)) begin
              state <= S_B2_CHK;
            end else begin
              cnt   <= cnt - CW'(1);
              e     <= e << 1;
              state <= S_B2_SQ;
            end
          end
        end

        S_B2_CHK: begin
          if (x == W'(1) || x == nm1) begin
            mag   <= MAG_W'(5);
            neg   <= 1'b0;
            tries <= '0;
            red     <= XW'(5);
            red_neg <= 1'b0;
            state <= S_D_RED;
          end else begin
            r     <= SW'(1);
            state <= S_B2_LOOP;
          end
        end

        S_B2_LOOP: begin
          if (r < s) begin
            state <= S_B2_LSQ;
          end else begin
            res_code <= VERDICT_COMPOSITE;
            state    <= S_FIN;
          end
        end

        S_B2_LSQ: begin
          if (alu_done) begin
            x <= alu_res;
            if (alu_res == nm1) begin
              mag     <= MAG_W'(5);
              neg     <= 1'b0;
              tries   <= '0;
              red     <= XW'(5);
              red_neg <= 1'b0;
              state   <= S_D_RED;
            end else if (alu_res == W'(1)) begin
              res_code <= VERDICT_COMPOSITE;
              state    <= S_FIN;
            end else begin
              r     <= r + SW'(1);
              state <= S_B2_LOOP;
            end
          end
        end

        // Selfridge search: reduce D by repeated subtraction, then Jacobi.
        S_D_RED: begin
          if (red >= n_ext) begin
            red <= red - n_ext;
          end else begin
            dm    <= red_res;
            state <= S_D_JAC;
          end
        end

        S_D_JAC: begin
          if (jac_done) begin
            if (jac_symbol == JAC_MINUS) begin
              red     <= neg ? XW'((mag + MAG_W'(1)) >> 2) : XW'((mag - MAG_W'(1)) >> 2);
              red_neg <= !neg;
              state   <= S_Q_RED;
            end else if (jac_symbol == JAC_ZERO && XW'(mag) != n_ext) begin
              res_code <= VERDICT_COMPOSITE;
              state    <= S_FIN;
            end else if (tries == TW'(MAX_D_TRIES - 1)) begin
              res_code <= VERDICT_SQUARE;
              state    <= S_FIN;
            end else begin
              tries   <= tries + TW'(1);
              mag     <= mag + MAG_W'(2);
              neg     <= !neg;
              red     <= XW'(mag + MAG_W'(2));
              red_neg <= !neg;
              state   <= S_D_RED;
            end
          end
        end

        S_Q_RED: begin
          if (red >= n_ext) begin
            red <= red - n_ext;
          end else begin
            qm    <= red_res;
            e     <= {1'b0, n} + EW'(1);
            s     <= '0;
            state <= S_L_STRIP;
          end
        end

        // Strong Lucas test with P = 1: doubling, then an add step on a one bit.
        S_L_STRIP: begin
          if (!e[0]) begin
            e <= e >> 1;
            s <= s + SW'(1);
          end else begin
            cnt   <= CW'(EW);
            u     <= '0;
            v     <= W'(2);
            qk    <= W'(1);
            state <= S_L_UV;
          end
        end

        S_L_UV: begin
          if (alu_done) begin
            u     <= alu_res;
            state <= S_L_VV;
          end
        end

        S_L_VV: begin
          if (alu_done) begin
            t     <= alu_res;
            state <= S_L_QQ2;
          end
        end

        S_L_QQ2: begin
          if (alu_done) begin
            w     <= alu_res;
            state <= S_L_VSUB;
          end
        end

        S_L_VSUB: begin
          if (alu_done) begin
            v     <= alu_res;
            state <= S_L_QSQ;
          end
        end

        S_L_QSQ: begin
          if (alu_done) begin
            qk <= alu_res;
            if (e[EW-1]) begin
              state <= S_L_ADD;
            end else if (cnt == CW'(1)) begin
              state <= S_L_CHK;
            end else begin
              cnt   <= cnt - CW'(1);
              e     <= e << 1;
              state <= S_L_UV;
            end
          end
        end

        S_L_ADD: begin
          if (alu_done) begin
            t     <= alu_res;
            state <= S_L_HALF;
          end
        end

        S_L_HALF: begin
          if (alu_done) begin
            t     <= alu_res;
            state <= S_L_DU;
          end
        end

        S_L_DU: begin
          if (alu_done) begin
            w     <= alu_res;
            state <= S_L_DUV;
          end
        end

        S_L_DUV: begin
          if (alu_done) begin
            w     <= alu_res;
            state <= S_L_HALF2;
          end
        end

        S_L_HALF2: begin
          if (alu_done) begin
            v     <= alu_res;
            u     <= t;
            state <= S_L_QM;
          end
        end

        S_L_QM: begin
          if (alu_done) begin
            qk <= alu_res;
            if (cnt == CW'(1)) begin
              state <= S_L_CHK;
            end else begin
              cnt   <= cnt - CW'(1);
              e     <= e << 1;
              state <= S_L_UV;
            end
          end
        end

        S_L_CHK: begin
          if (u == '0 || v == '0) begin
            res_code <= VERDICT_PRIME;
            state    <= S_FIN;
          end else begin
            r     <= SW'(1);
            state <= S_LV_LOOP;
          end
        end

        S_LV_LOOP: begin
          if (r < s) begin
            state <= S_LV_VV;
          end else begin
            res_code <= VERDICT_COMPOSITE;
            state    <= S_FIN;
          end
        end

        S_LV_VV: begin
          if (alu_done) begin
            t     <= alu_res;
            state <= S_LV_QQ2;
          end
        end

        S_LV_QQ2: begin
          if (alu_done) begin
            w     <= alu_res;
            state <= S_LV_VSUB;
          end
        end

        S_LV_VSUB: begin
          if (alu_done) begin
            v     <= alu_res;
            state <= S_LV_QSQ;
          end
        end

        S_LV_QSQ: begin
          if (alu_done) begin
            qk <= alu_res;
            if (v == '0) begin
              res_code <= VERDICT_PRIME;
              state    <= S_FIN;
            end else begin
              r     <= r + SW'(1);
              state <= S_LV_LOOP;
            end
          end
        end

        S_FIN: begin
          if (load_out) begin
            verdict <= res_code;
            state   <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_CHECK))
    else $error("accepted word did not start a classification");

  a_alu_owned: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> pend)
    else $error("modular unit finished with no request outstanding");

  a_jac_owned: assert property (@(posedge clk) disable iff (rst)
    jac_done |-> (state == S_D_JAC))
    else $error("Jacobi result arrived outside the D search");

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !(out_valid && out_stall)) |=> (out_valid && state == S_IDLE))
    else $error("finished verdict was not loaded into the output");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (verdict == VERDICT_COMPOSITE || verdict == VERDICT_PRIME ||
                   verdict == VERDICT_SQUARE))
    else $error("verdict holds an unused code");

endmodule

[dv/tb_baillie_psw_primality_test.sv]
`timescale 1ns / 1ps

module tb_baillie_psw_primality_test;
  import bpsw_pkg::*;

  localparam int D_TRIES  = 64;

  // One pending input word. A word marked drain_first is held back until
  // every verdict already owed has come out of the block.
  typedef struct {
    logic [62:0] value;
    bit          drain_first;
  } cand_item_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [62:0] candidate;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  verdict;

  cand_item_t  pending_cands[$];
  logic [1:0]  owed_verdicts[$];
  logic [62:0] owed_cands[$];

  int mismatch_count = 0;
  int words_sent     = 0;
  int verdicts_seen  = 0;
  int prime_seen     = 0;
  int square_seen    = 0;

  baillie_psw_primality_test u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .candidate (candidate),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .verdict   (verdict)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------
  // Verdict predictor. All residues stay in [0, n); products are taken at
  // full width and reduced, so nothing can overflow for n below 2^63.
  // ---------------------------------------------------------------------
  function automatic logic [63:0] prod_mod(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    logic [127:0] p;
    p = {64'd0, a % n} * {64'd0, b % n};
    return 64'(p % {64'd0, n});
  endfunction

  function automatic logic [63:0] sum_mod(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, n}) s = s - {1'b0, n};
    return s[63:0];
  endfunction

  function automatic logic [63:0] diff_mod(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    return (a >= b) ? a - b : n - (b - a);
  endfunction

  // Halving modulo an odd n: odd residues borrow n before the shift.
  function automatic logic [63:0] halve_mod(logic [63:0] x, logic [63:0] n);
    return x[0] ? (x >> 1) + (n >> 1) + 64'd1 : x >> 1;
  endfunction

  function automatic logic [63:0] exp_mod(logic [63:0] base, logic [63:0] e, logic [63:0] n);
    logic [63:0] r;
    r = 64'd1 % n;
    base = base % n;
    while (e != 0) begin
      if (e[0]) r = prod_mod(r, base, n);
      base = prod_mod(base, base, n);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic logic [63:0] small_residue(longint v, logic [63:0] n);
    logic [63:0] r;
    if (v >= 0) return 64'(v) % n;
    r = 64'(-v) % n;
    return (r == 0) ? 64'd0 : n - r;
  endfunction

  // Returns JAC_PLUS, JAC_MINUS or JAC_ZERO for (a/n), n odd.
  function automatic logic [1:0] jacobi_code(logic [63:0] a, logic [63:0] n);
    bit          neg;
    logic [63:0] t;
    neg = 1'b0;
    while (a != 0) begin
      while (!a[0]) begin
        a = a >> 1;
        if (n[2:0] == 3'd3 || n[2:0] == 3'd5) neg = ~neg;
      end
      t = a; a = n; n = t;
      if (a[1:0] == 2'd3 && n[1:0] == 2'd3) neg = ~neg;
      a = a % n;
    end
    if (n != 1) return JAC_ZERO;
    return neg ? JAC_MINUS : JAC_PLUS;
  endfunction

  function automatic bit passes_base2(logic [63:0] n);
    logic [63:0] d, x;
    int          s;
    d = n - 1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    x = exp_mod(64'd2, d, n);
    if (x == 1 || x == n - 1) return 1'b1;
    for (int r = 1; r < s; r++) begin
      x = prod_mod(x, x, n);
      if (x == n - 1) return 1'b1;
      if (x == 1) return 1'b0;
    end
    return 1'b0;
  endfunction

  // Strong Lucas test with P = 1, Q = (1 - D) / 4, walking the bits of the
  // odd part of n + 1 from the top.
  function automatic bit passes_lucas(logic [63:0] n, longint dsel);
    logic [63:0] dm, qm, k, u, v, qk, nu;
    int          s, top;
    dm = small_residue(dsel, n);
    qm = small_residue((1 - dsel) / 4, n);
    k  = n + 1;
    u  = 0;
    v  = 64'd2 % n;
    qk = 64'd1 % n;
    s  = 0;
    while (!k[0]) begin
      k = k >> 1;
      s++;
    end
    top = 63;
    while (top > 0 && !k[top]) top--;
    for (int i = top; i >= 0; i--) begin
      u  = prod_mod(u, v, n);
      v  = diff_mod(prod_mod(v, v, n), sum_mod(qk, qk, n), n);
      qk = prod_mod(qk, qk, n);
      if (k[i]) begin
        nu = halve_mod(sum_mod(u, v, n), n);
        v  = halve_mod(sum_mod(prod_mod(dm, u, n), v, n), n);
        u  = nu;
        qk = prod_mod(qk, qm, n);
      end
    end
    if (u == 0 || v == 0) return 1'b1;
    for (int r = 1; r < s; r++) begin
      v  = diff_mod(prod_mod(v, v, n), sum_mod(qk, qk, n), n);
      qk = prod_mod(qk, qk, n);
      if (v == 0) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [1:0] predict_verdict(logic [62:0] value);
    logic [63:0] n, mag;
    longint      dsel;
    logic [1:0]  jac;
    n = {1'b0, value};
    if (n < 2) return VERDICT_COMPOSITE;
    if (n == 2) return VERDICT_PRIME;
    if (!n[0]) return VERDICT_COMPOSITE;
    if (!passes_base2(n)) return VERDICT_COMPOSITE;
    dsel = 5;
    for (int tries = 0; tries < D_TRIES; tries++) begin
      mag = (dsel >= 0) ? 64'(dsel) : 64'(-dsel);
      jac = jacobi_code(small_residue(dsel, n), n);
      if (jac == JAC_MINUS)
        return passes_lucas(n, dsel) ? VERDICT_PRIME : VERDICT_COMPOSITE;
      // A zero symbol means D shares a factor with n, unless D is n itself.
      if (jac == JAC_ZERO && mag != n) return VERDICT_COMPOSITE;
      dsel = (dsel >= 0) ? -(dsel + 2) : -dsel + 2;
    end
    return VERDICT_SQUARE;
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------
  // Driver: offers words in bursts of random length separated by random
  // gaps. A word stays on the port until it is taken.
  // ---------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      candidate  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      automatic bit taken = in_valid && !in_stall;
      if (taken) begin
        owed_verdicts.push_back(predict_verdict(candidate));
        owed_cands.push_back(candidate);
        void'(pending_cands.pop_front());
        words_sent++;
      end
      if (in_valid && !taken) begin
        // Hold the stalled word as it is.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_cands.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_cands[0].drain_first && owed_verdicts.size() != 0) begin
        // Pause until the block has handed back everything it owes.
        in_valid <= 1'b0;
      end else begin
        in_valid  <= 1'b1;
        candidate <= pending_cands[0].value;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 6);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks every verdict taken against the oldest prediction and
  // drives out_stall from a pattern whose mode is redrawn at random. One long
  // hold-off lets the block fill up and stall its input.
  // ---------------------------------------------------------------------
  int stall_mode;
  int mode_left;
  int phase_cnt;
  int hold_left;
  bit hold_done;

  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_mode <= 0;
      mode_left  <= 0;
      phase_cnt  <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        verdicts_seen++;
        if (owed_verdicts.size() == 0) begin
          report_mismatch($sformatf("verdict %0d with no word outstanding", verdict));
        end else begin
          automatic logic [1:0]  want = owed_verdicts.pop_front();
          automatic logic [62:0] cand = owed_cands.pop_front();
          if (verdict !== want)
            report_mismatch($sformatf("candidate %0d: verdict %0d, predicted %0d",
                                      cand, verdict, want));
          if (want == VERDICT_PRIME) prime_seen++;
          if (want == VERDICT_SQUARE) square_seen++;
        end
      end

      phase_cnt <= phase_cnt + 1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && words_sent >= 30) begin
        // Long hold-off while the sender keeps offering words.
        hold_done <= 1'b1;
        hold_left <= 60000;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode <= $urandom_range(0, 2);
          mode_left  <= $urandom_range(100, 800);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (stall_mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_stall <= (phase_cnt % 9) < 4;
          end
        endcase
      end
    end
  end

  function automatic logic [62:0] rand_wide();
    return 63'({$urandom(), $urandom()});
  endfunction

  task automatic queue_cand(logic [62:0] value, bit drain_first = 1'b0);
    cand_item_t it;
    it.value       = value;
    it.drain_first = drain_first;
    pending_cands.push_back(it);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------
  initial begin
    logic [62:0] v;
    rst = 1'b1;

    // Directed words: trivial inputs, small primes where D equals n and is
    // skipped, base-2 strong pseudoprimes, squares of Wieferich primes that
    // exhaust the D search, and the widest values.
    queue_cand(63'd0);
    queue_cand(63'd1);
    queue_cand(63'd2);
    queue_cand(63'd4);
    queue_cand(63'd3);
    queue_cand(63'd5);
    queue_cand(63'd7);
    queue_cand(63'd11);
    queue_cand(63'd13);
    queue_cand(63'd9);
    queue_cand(63'd15);
    queue_cand(63'd2047);
    queue_cand(63'd3277);
    queue_cand(63'd1194649);
    queue_cand(63'd12327121);
    queue_cand(63'd5459);
    queue_cand(63'd65521);
    queue_cand(63'd3215031751);
    queue_cand(63'h7FFF_FFFF_FFFF_FFFF);
    queue_cand(63'h7FFF_FFFF_FFFF_FFFE);
    queue_cand(63'd9223372036854775783);
    queue_cand(63'd2305843009213693951);
    queue_cand(63'h5555_5555_5555_5555, 1'b1);

    // Random words: mostly small odd numbers, which get through the base-2
    // test and into the D search often; a few medium and full-width ones
    // toggle every input bit; some even numbers as noise.
    for (int i = 0; i < 80; i++) begin
      case ($urandom_range(0, 9))
        0: v = rand_wide();
        1: v = 63'($urandom_range(0, 65535)) & ~63'd1;
        2, 3: v = 63'($urandom_range(3, 24'hFF_FFFF)) | 63'd1;
        default: v = 63'($urandom_range(3, 4095)) | 63'd1;
      endcase
      queue_cand(v, (i == 50));
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    wait (pending_cands.size() == 0);
    while (owed_verdicts.size() != 0 || in_valid) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Classified %0d words, %0d verdicts checked: %0d probable primes, %0d squares.",
             words_sent, verdicts_seen, prime_seen, square_seen);
    $display("Covered trivial inputs, D search skips, pseudoprimes and output back-pressure.");
    if (mismatch_count == 0 && owed_verdicts.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Limit well beyond the slowest correct run.
  initial begin
    #250ms;
    $display("Timeout with %0d verdicts outstanding.", owed_verdicts.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
